FILE: src/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition in one cycle leads to another in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/utf8wlc_pkg.sv
package utf8wlc_pkg;

  // Counter width and saturation limit
  localparam int COUNT_BITS = 48;
  typedef logic [COUNT_BITS-1:0] count_t;
  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [7:0]  byte_t;
  typedef logic [19:0] space_mask_t;
  typedef logic [6:0]  dfa_state_t;
  typedef logic [4:0]  dfa_sub_t;

  localparam space_mask_t SPACE_MASK_RST = 20'd900092;

  // Automaton state codes
  localparam dfa_state_t ST_SPACE    = 7'd0;
  localparam dfa_state_t ST_NL       = 7'd1;
  localparam dfa_state_t ST_NEWWORD  = 7'd2;
  localparam dfa_state_t ST_WORD     = 7'd3;
  localparam dfa_state_t SIDE0_BASE  = 7'd4;
  localparam dfa_state_t SIDE1_BASE  = 7'd21;
  localparam dfa_state_t NSUB        = 7'd17;

  // Pending sub-state codes
  localparam dfa_sub_t P_LAST      = 5'd0;
  localparam dfa_sub_t P_LAST_C2   = 5'd1;
  localparam dfa_sub_t P_LAST_E19A = 5'd2;
  localparam dfa_sub_t P_LAST_E280 = 5'd3;
  localparam dfa_sub_t P_LAST_E281 = 5'd4;
  localparam dfa_sub_t P_LAST_E380 = 5'd5;
  localparam dfa_sub_t P_E0        = 5'd6;
  localparam dfa_sub_t P_E1        = 5'd7;
  localparam dfa_sub_t P_E2        = 5'd8;
  localparam dfa_sub_t P_E3        = 5'd9;
  localparam dfa_sub_t P_ED        = 5'd10;
  localparam dfa_sub_t P_E         = 5'd11;
  localparam dfa_sub_t P_F0        = 5'd12;
  localparam dfa_sub_t P_F4        = 5'd13;
  localparam dfa_sub_t P_F         = 5'd14;
  localparam dfa_sub_t P_NEED2     = 5'd15;
  localparam dfa_sub_t P_BAD       = 5'd16;

endpackage

FILE: src/utf8_word_line_counter.sv
// Channel | Direction | Handshake          | Carries
// in_     | input     | in_valid/in_stall  | byte_value, end_of_chunk, start_of_stream
// out_    | output    | out_valid/out_stall| line/word/char/byte totals, ends_in_space
// cfg_    | input     | cfg_valid/cfg_ready| unicode_space_mask (always ready)
//
// Takes one word per cycle while in_stall is low; the automaton step and the four saturating
// counter updates are combinational logic between the input and result registers.
// A chunk total passes the input register, then the result register, to reach out_.
// Reset (synchronous, rst_n low) clears automaton, counters and mask to defaults.
// A stalled result holds only words that end a chunk; other words keep flowing.
module utf8_word_line_counter (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  utf8wlc_pkg::byte_t       in_byte_value,
  input  logic                     in_end_of_chunk,
  input  logic                     in_start_of_stream,
  output logic                     out_valid,
  input  logic                     out_stall,
  output utf8wlc_pkg::count_t      out_line_total,
  output utf8wlc_pkg::count_t      out_word_total,
  output utf8wlc_pkg::count_t      out_char_total,
  output utf8wlc_pkg::count_t      out_byte_total,
  output logic                     out_ends_in_space,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  utf8wlc_pkg::space_mask_t cfg_unicode_space_mask
);
  import utf8wlc_pkg::*;

  // Map a side and a sub-state to a pending state code
  function automatic dfa_state_t pend(input logic side, input dfa_sub_t sub);
    return (side ? SIDE1_BASE : SIDE0_BASE) + dfa_state_t'(sub);
  endfunction

  // Step from a settled state on a fresh byte
  function automatic dfa_state_t fresh_byte(input logic side, input byte_t c);
    if (c < 8'h80) begin
      if (c == 8'h0A) return ST_NL;
      if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return ST_SPACE;
      return side ? ST_WORD : ST_NEWWORD;
    end
    if (c < 8'hC2) return pend(side, P_BAD);
    if (c == 8'hC2) return pend(side, P_LAST_C2);
    if (c < 8'hE0) return pend(side, P_LAST);
    if (c == 8'hE0) return pend(side, P_E0);
    if (c == 8'hE1) return pend(side, P_E1);
    if (c == 8'hE2) return pend(side, P_E2);
    if (c == 8'hE3) return pend(side, P_E3);
    if (c == 8'hED) return pend(side, P_ED);
    if (c < 8'hF0) return pend(side, P_E);
    if (c == 8'hF0) return pend(side, P_F0);
    if (c < 8'hF4) return pend(side, P_F);
    if (c == 8'hF4) return pend(side, P_F4);
    return pend(side, P_BAD);
  endfunction

  // Close a character on its side
  function automatic dfa_state_t finish(input logic side, input logic blank);
    if (blank) return ST_SPACE;
    return side ? ST_WORD : ST_NEWWORD;
  endfunction

  // Step inside a multi-byte sequence
  function automatic dfa_state_t pending_byte(input logic side, input dfa_sub_t sub,
                                              input byte_t c, input space_mask_t m);
    logic [4:0] zs_idx;
    zs_idx = 5'(c[3:0]) + 5'd3;
    if (c < 8'h80 || sub == P_BAD) return fresh_byte(side, c);
    if (c >= 8'hC0) return pend(side, P_BAD);
    unique case (sub)
      P_LAST:      return finish(side, 1'b0);
      P_LAST_C2:   return finish(side, (c == 8'h85 && m[0]) || (c == 8'hA0 && m[1]));
      P_LAST_E19A: return finish(side, c == 8'h80 && m[2]);
      P_LAST_E280: begin
        if (c <= 8'h8B) return finish(side, m[zs_idx]);
        if (c == 8'hA8) return finish(side, m[15]);
        if (c == 8'hA9) return finish(side, m[16]);
        if (c == 8'hAF) return finish(side, m[17]);
        return finish(side, 1'b0);
      end
      P_LAST_E281: return finish(side, c == 8'h9F && m[18]);
      P_LAST_E380: return finish(side, c == 8'h80 && m[19]);
      P_E0:        return pend(side, (c >= 8'hA0) ? P_LAST : P_BAD);
      P_E1:        return pend(side, (c == 8'h9A) ? P_LAST_E19A : P_LAST);
      P_E2: begin
        if (c == 8'h80) return pend(side, P_LAST_E280);
        if (c == 8'h81) return pend(side, P_LAST_E281);
        return pend(side, P_LAST);
      end
      P_E3:        return pend(side, (c == 8'h80) ? P_LAST_E380 : P_LAST);
      P_ED:        return pend(side, (c < 8'hA0) ? P_LAST : P_BAD);
      P_E:         return pend(side, P_LAST);
      P_F0:        return pend(side, (c >= 8'h90) ? P_NEED2 : P_BAD);
      P_F4:        return pend(side, (c < 8'h90) ? P_NEED2 : P_BAD);
      P_F:         return pend(side, P_NEED2);
      P_NEED2:     return pend(side, P_LAST);
      default:     return pend(side, P_BAD);
    endcase
  endfunction

  // Full automaton step
  function automatic dfa_state_t next_state(input dfa_state_t s, input byte_t c,
                                            input space_mask_t m);
    if (s <= ST_NL) return fresh_byte(1'b0, c);
    if (s <= ST_WORD) return fresh_byte(1'b1, c);
    if (s < SIDE1_BASE) return pending_byte(1'b0, dfa_sub_t'(s - SIDE0_BASE), c, m);
    if (s < SIDE1_BASE + NSUB) return pending_byte(1'b1, dfa_sub_t'(s - SIDE1_BASE), c, m);
    return pend(1'b1, P_BAD);
  endfunction

  function automatic count_t sat_inc(input count_t v);
    return (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

  // Input register
  logic        a_valid_r, a_valid_nxt;
  byte_t       a_byte_r;
  logic        a_eoc_r;
  logic        a_sos_r;
  logic        a_adv;
  logic        out_free;
  logic        in_take;

  // Stream state
  space_mask_t mask_r;
  dfa_state_t  dfa_state_r, dfa_state_nxt;
  count_t      line_r, word_r, char_r, byte_r;
  count_t      line_nxt, word_nxt, char_nxt, byte_nxt;
  logic        chw_r, chw_nxt;

  // Result register
  logic        out_valid_r;
  count_t      out_line_r, out_word_r, out_char_r, out_byte_r;
  logic        out_eis_r;

  // Step values
  dfa_state_t  base_state;
  count_t      line_base, word_base, char_base, byte_base;
  logic        chw_base, chw_after, char_done, eis;

  // Handshakes
  assign out_free    = !out_valid_r || !out_stall;
  assign a_adv       = a_valid_r && (!a_eoc_r || out_free);
  assign in_stall    = a_valid_r && !a_adv;
  assign in_take     = in_valid && !in_stall;
  assign a_valid_nxt = in_take || (a_valid_r && !a_adv);
  assign cfg_ready   = 1'b1;

  // Clear on stream start, then step the automaton and counters
  always_comb begin
    base_state    = a_sos_r ? ST_SPACE : dfa_state_r;
    line_base     = a_sos_r ? '0 : line_r;
    word_base     = a_sos_r ? '0 : word_r;
    char_base     = a_sos_r ? '0 : char_r;
    byte_base     = a_sos_r ? '0 : byte_r;
    chw_base      = a_sos_r ? 1'b0 : chw_r;
    dfa_state_nxt = next_state(base_state, a_byte_r, mask_r);
    char_done     = dfa_state_nxt < SIDE0_BASE;
    byte_nxt      = sat_inc(byte_base);
    char_nxt      = char_done ? sat_inc(char_base) : char_base;
    line_nxt      = (dfa_state_nxt == ST_NL) ? sat_inc(line_base) : line_base;
    word_nxt      = (dfa_state_nxt == ST_NEWWORD) ? sat_inc(word_base) : word_base;
    chw_after     = chw_base || (dfa_state_nxt == ST_NEWWORD);
    eis           = (dfa_state_nxt == ST_SPACE || dfa_state_nxt == ST_NL) && !chw_after;
    chw_nxt       = a_eoc_r ? 1'b0 : chw_after;
  end

  // Capture an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
    if (in_take) begin
      a_byte_r <= in_byte_value;
      a_eoc_r  <= in_end_of_chunk;
      a_sos_r  <= in_start_of_stream;
    end
  end

  // Advance the stream state and take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= SPACE_MASK_RST;
      dfa_state_r <= ST_SPACE;
      line_r      <= '0;
      word_r      <= '0;
      char_r      <= '0;
      byte_r      <= '0;
      chw_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_unicode_space_mask;
      end
      if (a_adv) begin
        dfa_state_r <= dfa_state_nxt;
        line_r      <= line_nxt;
        word_r      <= word_nxt;
        char_r      <= char_nxt;
        byte_r      <= byte_nxt;
        chw_r       <= chw_nxt;
      end
    end
  end

  // Load totals at a chunk end, drop them once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_adv && a_eoc_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (a_adv && a_eoc_r) begin
      out_line_r <= line_nxt;
      out_word_r <= word_nxt;
      out_char_r <= char_nxt;
      out_byte_r <= byte_nxt;
      out_eis_r  <= eis;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_total    = out_line_r;
  assign out_word_total    = out_word_r;
  assign out_char_total    = out_char_r;
  assign out_byte_total    = out_byte_r;
  assign out_ends_in_space = out_eis_r;

endmodule

FILE: src/utf8wlc_checker.sv
`include "assert_macros.svh"

module utf8wlc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input utf8wlc_pkg::count_t out_line_total,
  input utf8wlc_pkg::count_t out_word_total,
  input utf8wlc_pkg::count_t out_char_total,
  input utf8wlc_pkg::count_t out_byte_total
);
  import utf8wlc_pkg::*;

  // Hold a stalled result valid with a stable byte total
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte_total), "stalled result changed")

  // Every counted character is built from at least one byte
  `ASSERT_ALWAYS(a_char_le_byte, clk, rst_n, !out_valid || (out_char_total <= out_byte_total), "char total above byte total")

  // Newlines and word starts are both completed characters
  `ASSERT_ALWAYS(a_line_word_le_char, clk, rst_n, !out_valid || ((out_line_total <= out_char_total) && (out_word_total <= out_char_total)), "line or word total above char total")

endmodule

bind utf8_word_line_counter utf8wlc_checker u_utf8wlc_checker (.*);
